// ===== rtl/core/lkvc_pkg.sv =====
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value_in;
  } lkvc_req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value_out;
    logic                     evicted;
  } lkvc_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PROMOTE,
    ST_FINISH
  } lkvc_state_e;

endpackage

// ===== rtl/core/lkvc_store.sv =====
// entry store: key, value and recency rank memories with registered reads
module lkvc_store import lkvc_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_key_o,
  output logic [DATA_W-1:0] rd_val_o,
  output logic [IDX_W-1:0]  rd_rank_o,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic              key_we_i,
  input  logic              val_we_i,
  input  logic              rank_we_i,
  input  logic [DATA_W-1:0] key_wdata_i,
  input  logic [DATA_W-1:0] val_wdata_i,
  input  logic [IDX_W-1:0]  rank_wdata_i
);

  logic [DATA_W-1:0] key_mem  [DEPTH];
  logic [DATA_W-1:0] val_mem  [DEPTH];
  logic [IDX_W-1:0]  rank_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[wr_addr_i] <= key_wdata_i;
    end
    if (val_we_i) begin
      val_mem[wr_addr_i] <= val_wdata_i;
    end
    if (rank_we_i) begin
      rank_mem[wr_addr_i] <= rank_wdata_i;
    end
    rd_key_o  <= key_mem[rd_addr_i];
    rd_val_o  <= val_mem[rd_addr_i];
    rd_rank_o <= rank_mem[rd_addr_i];
  end

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// top level of the lru key-value cache: sequencer, scan and recency update
//
// channel   direction  payload      handshake
// request   in         lkvc_req_t   req_valid_i / req_stall_o
// response  out        lkvc_rsp_t   rsp_valid_o / rsp_stall_i
// config    in         5-bit cap    cfg_we_i, no wait
//
// a request passes from acceptance to response through a scan of all entries
// through the single read port of the store, then a recency pass over the same
// port (skipped on a get miss), then a write-back.
// the store needs no clearing after reset; only the valid bits are cleared.
// a stalled response holds the write-back until it is taken.
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  lkvc_req_t        req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output lkvc_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W:0] CNT_END = (IDX_W + 1)'(MAX_ENTRIES);
  localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_ENTRIES);

  lkvc_state_e state_q, state_d;

  logic [CAP_W-1:0]       cap_q;
  logic [CNT_W-1:0]       occ_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [IDX_W:0]         cnt_q;
  logic                   pend_q;
  logic [IDX_W-1:0]       idx_q;

  // request fields
  logic              op_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;

  // scan results
  logic              hit_q, lru_ok_q, free_ok_q;
  logic [IDX_W-1:0]  hit_idx_q, hit_rank_q, lru_idx_q, lru_rank_q, free_idx_q;
  logic [DATA_W-1:0] hit_val_q;

  // decision
  logic              promote_d;
  logic              act_q, act_d;
  logic              all_q, all_d;
  logic              ev_q, ev_d;
  logic              grow_q, grow_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  limit_q, limit_d;
  logic [DATA_W-1:0] vout_q, vout_d;

  logic              rsp_valid_q;
  lkvc_rsp_t         rsp_q;

  logic              accept, issue, scan_done, pass_done, out_free, finish;
  logic              cur_valid, age_hit;
  logic [CMP_W-1:0]  cap_ext, eff_cap;

  logic [IDX_W-1:0]  rd_addr, wr_addr, rank_wdata;
  logic [DATA_W-1:0] rd_key, rd_val;
  logic [IDX_W-1:0]  rd_rank;
  logic              key_we, val_we, rank_we;

  lkvc_store #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .rd_key_o     (rd_key),
    .rd_val_o     (rd_val),
    .rd_rank_o    (rd_rank),
    .wr_addr_i    (wr_addr),
    .key_we_i     (key_we),
    .val_we_i     (val_we),
    .rank_we_i    (rank_we),
    .key_wdata_i  (key_q),
    .val_wdata_i  (val_q),
    .rank_wdata_i (rank_wdata)
  );

  assign req_stall_o = (state_q != ST_IDLE);
  assign accept      = req_valid_i && !req_stall_o;
  assign issue       = (cnt_q != CNT_END);
  assign scan_done   = (state_q == ST_SCAN) && !issue && !pend_q;
  assign pass_done   = (state_q == ST_PROMOTE) && !issue && !pend_q;
  assign out_free    = !rsp_valid_q || !rsp_stall_i;
  assign finish      = (state_q == ST_FINISH) && out_free;
  assign cur_valid   = valid_q[idx_q];
  assign rd_addr     = cnt_q[IDX_W-1:0];

  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_MAX) begin
      eff_cap = CMP_MAX;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // choice of slot and promotion limit after the scan
  always_comb begin
    promote_d = 1'b1;
    act_d     = 1'b1;
    all_d     = 1'b0;
    ev_d      = 1'b0;
    grow_d    = 1'b0;
    found_d   = 1'b0;
    slot_d    = hit_idx_q;
    limit_d   = hit_rank_q;
    vout_d    = '0;
    if (hit_q) begin
      found_d = 1'b1;
      if (op_q == OP_GET) begin
        vout_d = hit_val_q;
      end
    end else if (op_q == OP_GET) begin
      promote_d = 1'b0;
      act_d     = 1'b0;
      vout_d    = MISS_VALUE;
    end else if ((CMP_W'(occ_q) >= eff_cap) && lru_ok_q) begin
      ev_d    = 1'b1;
      slot_d  = lru_idx_q;
      limit_d = lru_rank_q;
    end else begin
      all_d  = 1'b1;
      grow_d = 1'b1;
      slot_d = free_idx_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = promote_d ? ST_PROMOTE : ST_FINISH;
        end
      end
      ST_PROMOTE: begin
        if (pass_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign age_hit = pend_q && cur_valid && (idx_q != slot_q) &&
                   (all_q || (rd_rank < limit_q));

  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    rank_we    = 1'b0;
    wr_addr    = slot_q;
    rank_wdata = '0;
    case (state_q)
      ST_PROMOTE: begin
        if (age_hit) begin
          rank_we    = 1'b1;
          wr_addr    = idx_q;
          rank_wdata = rd_rank + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free && act_q) begin
          rank_we = 1'b1;
          key_we  = (op_q == OP_SET);
          val_we  = (op_q == OP_SET);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      lru_ok_q    <= 1'b0;
      free_ok_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      pend_q <= 1'b0;
      if ((state_q == ST_SCAN || state_q == ST_PROMOTE) && issue) begin
        cnt_q  <= cnt_q + (IDX_W + 1)'(1);
        pend_q <= 1'b1;
      end
      if (accept || scan_done) begin
        cnt_q <= '0;
      end
      if (accept) begin
        hit_q     <= 1'b0;
        lru_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
      end
      if (state_q == ST_SCAN && pend_q) begin
        if (cur_valid && (rd_key == key_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cur_valid && (!lru_ok_q || (rd_rank > lru_rank_q))) begin
          lru_ok_q <= 1'b1;
        end
        if (!cur_valid && !free_ok_q) begin
          free_ok_q <= 1'b1;
        end
      end
      if (finish) begin
        if (act_q) begin
          valid_q[slot_q] <= 1'b1;
        end
        if (grow_q) begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end
      if (finish) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= rd_addr;
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
      val_q <= req_i.value_in;
    end
    if (state_q == ST_SCAN && pend_q) begin
      if (cur_valid && (rd_key == key_q) && !hit_q) begin
        hit_idx_q  <= idx_q;
        hit_rank_q <= rd_rank;
        hit_val_q  <= rd_val;
      end
      if (cur_valid && (!lru_ok_q || (rd_rank > lru_rank_q))) begin
        lru_idx_q  <= idx_q;
        lru_rank_q <= rd_rank;
      end
      if (!cur_valid && !free_ok_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (scan_done) begin
      act_q   <= act_d;
      all_q   <= all_d;
      ev_q    <= ev_d;
      grow_q  <= grow_d;
      found_q <= found_d;
      slot_q  <= slot_d;
      limit_q <= limit_d;
      vout_q  <= vout_d;
    end
    if (finish) begin
      rsp_q.found     <= found_q;
      rsp_q.value_out <= vout_q;
      rsp_q.evicted   <= ev_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
